@@ rtl/core/streaming_find_replace_all_core_assert.svh @@
// Assertion macros for the streaming find-and-replace core.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef STREAMING_FIND_REPLACE_ALL_CORE_ASSERT_SVH
`define STREAMING_FIND_REPLACE_ALL_CORE_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/core/sfr_pkg.sv @@
// Shared types and constants of the streaming find-and-replace core.
// No dependencies; used by every module of the core.
package sfr_pkg;

  // Window and replacement capacity in bytes.
  localparam int PatternMax = 8;
  localparam int ReplaceMax = 8;
  localparam int MaxBytes   = (PatternMax > ReplaceMax) ? PatternMax : ReplaceMax;
  localparam int QDepth     = 4;
  localparam logic [7:0]  CaseBit  = 8'h20;
  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CfgPatternBytes     = 3'd0,
    CfgPatternLen       = 3'd1,
    CfgReplacementBytes = 3'd2,
    CfgReplacementLen   = 3'd3,
    CfgIgnoreCase       = 3'd4,
    CfgStartPosition    = 3'd5
  } cfg_idx_e;

  // One queued command: a burst of output bytes produced by one input byte.
  typedef struct packed {
    logic [8*MaxBytes-1:0] bytes;  // byte i in bits 8i+7:8i, sent first to last
    logic [3:0]            count;  // number of bytes, zero for a count-only result
    logic                  fin;    // last burst of the text
    logic [31:0]           tally;  // replacement count after this input byte
  } cmd_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic [2:0] count;
    logic       empty;
    logic       full;
  } q_stat_t;

endpackage

@@ rtl/core/sfr_front.sv @@
// Front end: configuration registers, hold window and pattern matcher.
// Depends on sfr_pkg; produces at most one command per accepted input byte.
module sfr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write channel
  input  logic              cfg_valid_i,
  input  logic [2:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i,
  // input byte stream
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_final_i,
  // command push toward the queue
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output sfr_pkg::cmd_t     push_cmd_o
);

  logic [63:0] pat_bytes_q, rep_bytes_q;
  logic [3:0]  pat_len_q, rep_len_q;
  logic        ign_case_q;
  logic [31:0] start_pos_q;

  logic [sfr_pkg::PatternMax-1:0][7:0] win_q, win_d, win_app;
  logic [2:0]  hc_q, hc_d;
  logic [31:0] idx_q, idx_d;
  logic [31:0] tally_q, tally_d, tally_new;

  logic [3:0]  plen, rlen, hc_inc;
  logic        accept, pass, full, hit, all_eq;
  logic [3:0]  emit_cnt;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= 4'd1;
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
      ign_case_q  <= 1'b0;
      start_pos_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (sfr_pkg::cfg_idx_e'(cfg_index_i))
        sfr_pkg::CfgPatternBytes:     pat_bytes_q <= cfg_data_i;
        sfr_pkg::CfgPatternLen:       pat_len_q   <= cfg_data_i[3:0];
        sfr_pkg::CfgReplacementBytes: rep_bytes_q <= cfg_data_i;
        sfr_pkg::CfgReplacementLen:   rep_len_q   <= cfg_data_i[3:0];
        sfr_pkg::CfgIgnoreCase:       ign_case_q  <= cfg_data_i[0];
        sfr_pkg::CfgStartPosition:    start_pos_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Effective lengths with out-of-range values clamped.
  always_comb begin
    if (pat_len_q == 4'd0) begin
      plen = 4'd1;
    end else if (pat_len_q > 4'(sfr_pkg::PatternMax)) begin
      plen = 4'(sfr_pkg::PatternMax);
    end else begin
      plen = pat_len_q;
    end
    rlen = (rep_len_q > 4'(sfr_pkg::ReplaceMax)) ? 4'(sfr_pkg::ReplaceMax) : rep_len_q;
  end

  assign accept     = in_valid_i && push_ready_i;
  assign in_ready_o = push_ready_i;
  assign hc_inc     = {1'b0, hc_q} + 4'd1;

  // Window with the new byte appended after the held bytes.
  always_comb begin
    for (int i = 0; i < sfr_pkg::PatternMax; i++) begin
      win_app[i] = (3'(i) == hc_q) ? in_byte_i : win_q[i];
    end
  end

  // Compare the full window against the pattern, case folded if enabled.
  always_comb begin
    logic [7:0] a, p;
    all_eq = 1'b1;
    for (int i = 0; i < sfr_pkg::PatternMax; i++) begin
      a = win_app[i];
      p = pat_bytes_q[8*i +: 8];
      if (ign_case_q) begin
        a = a | sfr_pkg::CaseBit;
        p = p | sfr_pkg::CaseBit;
      end
      if ((4'(i) < plen) && (a != p)) begin
        all_eq = 1'b0;
      end
    end
  end

  assign pass = (idx_q < start_pos_q) || ({1'b0, hc_q} >= plen);
  assign full = !pass && (hc_inc == plen);
  assign hit  = full && all_eq;

  // Number of bytes this input byte releases.
  always_comb begin
    if (hit) begin
      emit_cnt = rlen;
    end else if (pass || in_final_i) begin
      emit_cnt = hc_inc;
    end else if (full) begin
      emit_cnt = 4'd1;
    end else begin
      emit_cnt = 4'd0;
    end
  end

  assign tally_new = (hit && (tally_q != sfr_pkg::CountMax)) ? tally_q + 32'd1 : tally_q;

  // Command toward the back end.
  always_comb begin
    push_cmd_o.bytes = hit ? rep_bytes_q : win_app;
    push_cmd_o.count = emit_cnt;
    push_cmd_o.fin   = in_final_i;
    push_cmd_o.tally = tally_new;
  end
  assign push_valid_o = accept && ((emit_cnt != 4'd0) || in_final_i);

  // Next window state.
  always_comb begin
    win_d   = win_q;
    hc_d    = hc_q;
    tally_d = tally_new;
    idx_d   = (idx_q == sfr_pkg::CountMax) ? idx_q : idx_q + 32'd1;
    if (pass || hit) begin
      hc_d = 3'd0;
    end else if (full) begin
      for (int i = 0; i < sfr_pkg::PatternMax - 1; i++) begin
        win_d[i] = win_app[i+1];
      end
      win_d[sfr_pkg::PatternMax-1] = win_app[sfr_pkg::PatternMax-1];
      hc_d = 3'(plen - 4'd1);
    end else begin
      win_d = win_app;
      hc_d  = hc_inc[2:0];
    end
    if (in_final_i) begin
      hc_d    = 3'd0;
      idx_d   = '0;
      tally_d = '0;
    end
  end

  // Window, position and tally registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      hc_q    <= '0;
      idx_q   <= '0;
      tally_q <= '0;
    end else if (accept) begin
      win_q   <= win_d;
      hc_q    <= hc_d;
      idx_q   <= idx_d;
      tally_q <= tally_d;
    end
  end

endmodule

@@ rtl/core/sfr_queue.sv @@
// Command queue between the front end and the back end.
// Depends on sfr_pkg; a small register FIFO with the head shown combinationally.
module sfr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  sfr_pkg::cmd_t     push_cmd_i,
  input  logic              pop_i,
  output sfr_pkg::cmd_t     head_o,
  output sfr_pkg::q_stat_t  stat_o
);

  localparam int PtrW = $clog2(sfr_pkg::QDepth);

  sfr_pkg::cmd_t     entry_q [sfr_pkg::QDepth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [PtrW:0]     cnt_q;
  logic              do_push, do_pop;

  assign stat_o.count = 3'(cnt_q);
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (PtrW+1)'(sfr_pkg::QDepth));

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign head_o  = entry_q[rptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + PtrW'(1);
      if (do_pop)  rptr_q <= rptr_q + PtrW'(1);
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (PtrW+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (PtrW+1)'(1);
      end
    end
  end

endmodule

@@ rtl/core/sfr_back.sv @@
// Back end: serializes queued commands into output transactions.
// Depends on sfr_pkg; drives the registered output stream.
module sfr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sfr_pkg::cmd_t     head_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              out_present_o,
  output logic              out_end_o,
  output logic [31:0]       out_total_o
);

  logic [2:0]  k_q, k_d;
  logic        vld_q;
  logic [7:0]  byte_q;
  logic        pres_q, end_q;
  logic [31:0] total_q;
  logic [3:0]  n_eff;
  logic        load, last;

  // A count-only command still yields one transaction.
  assign n_eff = (head_i.count == 4'd0) ? 4'd1 : head_i.count;
  assign last  = ({1'b0, k_q} + 4'd1) == n_eff;
  assign load  = !q_empty_i && (!vld_q || out_ready_i);
  assign pop_o = load && last;
  assign k_d   = pop_o ? 3'd0 : k_q + 3'd1;

  // Output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      k_q   <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
        k_q   <= k_d;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q  <= (head_i.count == 4'd0) ? 8'd0 : head_i.bytes[8*k_q +: 8];
      pres_q  <= (head_i.count != 4'd0);
      end_q   <= last && head_i.fin;
      total_q <= head_i.tally;
    end
  end

  assign out_valid_o   = vld_q;
  assign out_byte_o    = byte_q;
  assign out_present_o = pres_q;
  assign out_end_o     = end_q;
  assign out_total_o   = total_q;

endmodule

@@ rtl/core/streaming_find_replace_all_core.sv @@
// Top level of the streaming find-and-replace core.
// Depends on sfr_pkg, sfr_front, sfr_queue, sfr_back and the assertion header.
//
// The core accepts one text byte per cycle and rewrites it: bytes before the
// start position pass through, later occurrences of the pattern (1 to 8 bytes,
// optionally case-insensitive) are replaced by the replacement text (0 to 8
// bytes). Each input byte releases between zero and eight output bytes; the
// front end classifies the byte as it is accepted and queues a burst command
// in a four-entry queue, and the back end sends the burst one byte per cycle
// from its output register while the receiver is ready. The input side keeps
// one byte per cycle as long as bursts average at most one byte per input
// byte; a burst occupies the back end until all of its bytes are sent, and
// the input stalls only while the queue is full. The final byte (tlast)
// flushes the held bytes and closes the text with tlast on the output; when
// nothing else is left, a count-only transaction (tuser low) carries the
// final replacement count.
`include "streaming_find_replace_all_core_assert.svh"

module streaming_find_replace_all_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // text_byte[7:0]
  input  logic        s_axis_tlast,   // is_final
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte[7:0], replace_total[39:8]
  output logic        m_axis_tuser,   // byte_present
  output logic        m_axis_tlast    // end_of_text
);

  sfr_pkg::cmd_t    push_cmd, head;
  sfr_pkg::q_stat_t q_stat;
  logic             push_valid, pop;
  logic [7:0]       out_byte;
  logic [31:0]      out_total;

  assign cfg_ready_o = 1'b1;

  // Front end: configuration, window and matching.
  sfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_final_i   (s_axis_tlast),
    .push_valid_o (push_valid),
    .push_ready_i (!q_stat.full),
    .push_cmd_o   (push_cmd)
  );

  // Burst command queue.
  sfr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push_valid),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .head_o     (head),
    .stat_o     (q_stat)
  );

  // Back end: byte serializer and output register.
  sfr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .q_empty_i     (q_stat.empty),
    .pop_o         (pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_byte_o    (out_byte),
    .out_present_o (m_axis_tuser),
    .out_end_o     (m_axis_tlast),
    .out_total_o   (out_total)
  );

  assign m_axis_tdata = {out_total, out_byte};

  // Checks on the queue and the back end.
  `SFR_ASSERT(a_q_bound, q_stat.count <= 3'(sfr_pkg::QDepth), "queue count above depth")
  `SFR_ASSERT(a_out_from_queue, m_axis_tvalid && !$past(m_axis_tvalid) |-> $past(!q_stat.empty), "output raised without a queued command")
  `SFR_ASSERT(a_count_only_last, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast, "count-only transaction not at end of text")

endmodule

@@ verif/streaming_find_replace_all_core_test.sv @@
// Self-checking testbench for the streaming find-and-replace core.
// Drives text over the input stream and checks the rewritten stream
// against a predictor of its own. Depends on sfr_pkg and the core RTL.
`timescale 1ns / 100ps

module streaming_find_replace_all_core_test;

  // One expected output transaction.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        present;
    logic        eot;
    logic [31:0] total;
  } text_beat_t;

  // Receiver behavior between long hold-offs.
  typedef enum int {
    RxAlways,
    RxRandom,
    RxPattern
  } rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;

  wire         cfg_ready_o;
  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [39:0] m_axis_tdata;   // out_byte[7:0], replace_total[39:8]
  wire         m_axis_tuser;   // byte_present
  wire         m_axis_tlast;   // end_of_text

  streaming_find_replace_all_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_data),
    .s_axis_tlast  (s_last),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the configuration registers.
  logic [63:0] cfg_pattern = '0;
  logic [3:0]  cfg_pat_len = 4'd1;
  logic [63:0] cfg_repl = '0;
  logic [3:0]  cfg_repl_len = 4'd0;
  logic        cfg_nocase = 1'b0;
  logic [31:0] cfg_start = '0;

  // Mirror of the rewrite state.
  logic [7:0]  held_bytes [0:sfr_pkg::PatternMax-1];
  int          held_cnt = 0;
  logic [31:0] text_pos = '0;
  logic [31:0] repl_count = '0;

  text_beat_t  expected_beats [$];
  text_beat_t  want;
  int          mismatches = 0;
  int          sent_items = 0;
  int          burst_left = 0;
  int          rx_hold_len = 0;
  int          rx_cycle = 0;
  rx_mode_e    rx_mode = RxAlways;

  // Case folding applied to both sides of a comparison.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    return cfg_nocase ? (b | sfr_pkg::CaseBit) : b;
  endfunction

  // Works out the output transactions caused by one input byte.
  function automatic void predict_rewrite(input logic [7:0] b, input logic fin);
    int          plen;
    int          rlen;
    int          n;
    int          i;
    logic        hit;
    logic [7:0]  ob [0:15];
    logic        op [0:15];
    text_beat_t  beat;
    plen = (cfg_pat_len == 0) ? 1 : ((cfg_pat_len > sfr_pkg::PatternMax) ?
                                     sfr_pkg::PatternMax : cfg_pat_len);
    rlen = (cfg_repl_len > sfr_pkg::ReplaceMax) ? sfr_pkg::ReplaceMax : cfg_repl_len;
    n = 0;
    if (text_pos < cfg_start || held_cnt >= plen) begin
      // Flush whatever is held, then pass the byte through.
      for (i = 0; i < held_cnt; i++) begin
        ob[n] = held_bytes[i];
        op[n] = 1'b1;
        n++;
      end
      held_cnt = 0;
      ob[n] = b;
      op[n] = 1'b1;
      n++;
    end else begin
      held_bytes[held_cnt] = b;
      held_cnt++;
      if (held_cnt == plen) begin
        hit = 1'b1;
        for (i = 0; i < plen; i++) begin
          if (fold_case(held_bytes[i]) != fold_case(cfg_pattern[8*i +: 8])) hit = 1'b0;
        end
        if (hit) begin
          for (i = 0; i < rlen; i++) begin
            ob[n] = cfg_repl[8*i +: 8];
            op[n] = 1'b1;
            n++;
          end
          held_cnt = 0;
          if (repl_count != sfr_pkg::CountMax) repl_count++;
        end else begin
          // No match: the oldest byte can no longer start one.
          ob[n] = held_bytes[0];
          op[n] = 1'b1;
          n++;
          for (i = 0; i < sfr_pkg::PatternMax - 1; i++) held_bytes[i] = held_bytes[i+1];
          held_cnt--;
        end
      end
    end
    if (text_pos != sfr_pkg::CountMax) text_pos++;
    if (fin) begin
      for (i = 0; i < held_cnt; i++) begin
        ob[n] = held_bytes[i];
        op[n] = 1'b1;
        n++;
      end
      held_cnt = 0;
      if (n == 0) begin
        ob[0] = 8'h00;
        op[0] = 1'b0;
        n = 1;
      end
    end
    for (i = 0; i < n; i++) begin
      beat.out_byte = ob[i];
      beat.present  = op[i];
      beat.eot      = fin && (i == n - 1);
      beat.total    = repl_count;
      expected_beats.push_back(beat);
    end
    if (fin) begin
      text_pos = '0;
      held_cnt = 0;
      repl_count = '0;
    end
  endfunction

  // Writes one register; valid stays high so writes can follow back to back.
  task automatic write_reg(input sfr_pkg::cfg_idx_e idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    case (idx)
      sfr_pkg::CfgPatternBytes:     cfg_pattern  = val;
      sfr_pkg::CfgPatternLen:       cfg_pat_len  = val[3:0];
      sfr_pkg::CfgReplacementBytes: cfg_repl     = val;
      sfr_pkg::CfgReplacementLen:   cfg_repl_len = val[3:0];
      sfr_pkg::CfgIgnoreCase:       cfg_nocase   = val[0];
      sfr_pkg::CfgStartPosition:    cfg_start    = val[31:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    cfg_valid <= 1'b0;
  endtask

  task automatic load_config(input logic [63:0] pat, input logic [3:0] plen,
                             input logic [63:0] repl, input logic [3:0] rlen,
                             input logic nocase, input logic [31:0] start);
    write_reg(sfr_pkg::CfgPatternBytes, pat);
    write_reg(sfr_pkg::CfgPatternLen, {60'd0, plen});
    write_reg(sfr_pkg::CfgReplacementBytes, repl);
    write_reg(sfr_pkg::CfgReplacementLen, {60'd0, rlen});
    write_reg(sfr_pkg::CfgIgnoreCase, {63'd0, nocase});
    write_reg(sfr_pkg::CfgStartPosition, {32'd0, start});
    cfg_done();
  endtask

  // Offers one byte and predicts its results once the transaction completes.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= fin;
    @(negedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    @(posedge clk_i);
    predict_rewrite(b, fin);
    sent_items++;
  endtask

  task automatic send_text(input string s, input logic close);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], close && (i == s.len() - 1));
  endtask

  // Sender bursts of random length separated by random gaps.
  task automatic pace_sender();
    int gap_len;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      gap_len = $urandom_range(0, 5);
      if (gap_len > 0) begin
        s_valid <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // Waits until every expected transaction has arrived and the core is quiet.
  task automatic drain_and_settle();
    s_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [63:0] pack_text(input string s);
    logic [63:0] v;
    int          i;
    v = '0;
    for (i = 0; i < s.len() && i < 8; i++) v[8*i +: 8] = s[i];
    return v;
  endfunction

  task automatic compare_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Receiver: a long hold-off when requested, otherwise the current pattern.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_len > 0) begin
        m_ready <= 1'b0;
        repeat (rx_hold_len - 1) @(posedge clk_i);
        rx_hold_len = 0;
      end else begin
        rx_cycle++;
        case (rx_mode)
          RxAlways:  m_ready <= 1'b1;
          RxRandom:  m_ready <= ($urandom_range(0, 3) != 0);
          RxPattern: m_ready <= ((rx_cycle % 7) >= 3);
          default:   m_ready <= 1'b1;
        endcase
      end
    end
  end

  // Output checker; the transaction seen here completes at the next edge.
  always @(negedge clk_i) begin
    if (rst_n && m_axis_tvalid && m_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual byte %h total %h",
                 $time, m_axis_tdata[7:0], m_axis_tdata[39:8]);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        compare_field("out_byte", {24'd0, want.out_byte}, {24'd0, m_axis_tdata[7:0]});
        compare_field("byte_present", {31'd0, want.present}, {31'd0, m_axis_tuser});
        compare_field("end_of_text", {31'd0, want.eot}, {31'd0, m_axis_tlast});
        compare_field("replace_total", want.total, m_axis_tdata[39:8]);
      end
    end
  end

  // Reset values: a one-byte pattern of zero with an empty replacement.
  task automatic test_reset_defaults();
    rx_mode = RxAlways;
    send_byte(8'h00, 1'b0);
    send_byte(8'h41, 1'b1);
    drain_and_settle();
  endtask

  // Expanding replacement, overlapping prefix and a partial match at the end.
  task automatic test_basic_replace();
    rx_mode = RxRandom;
    load_config(pack_text("ab"), 4'd2, pack_text("XYZ"), 4'd3, 1'b0, 32'd0);
    send_text("aaba", 1'b1);
    drain_and_settle();
  endtask

  // Case folding also applies to non-letters such as '@' and '`'.
  task automatic test_ignore_case();
    rx_mode = RxPattern;
    load_config(pack_text("c@T"), 4'd3, pack_text("k"), 4'd1, 1'b1, 32'd0);
    send_text("C`t", 1'b1);
    drain_and_settle();
  endtask

  // Out-of-range lengths, deletion and a count-only final transaction.
  task automatic test_length_limits();
    rx_mode = RxRandom;
    load_config(pack_text("q"), 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 32'd0);
    send_text("q", 1'b1);
    drain_and_settle();
    load_config(pack_text("ABCDEFGH"), 4'd15, pack_text("12345678"), 4'd15, 1'b0, 32'd0);
    send_text("ABCDEFGH", 1'b1);
    drain_and_settle();
  endtask

  // Bytes ahead of the start position are copied.
  task automatic test_start_position();
    rx_mode = RxAlways;
    load_config(pack_text("xy"), 4'd2, pack_text("Z"), 4'd1, 1'b0, 32'd2);
    send_text("xyxy", 1'b1);
    drain_and_settle();
  endtask

  // Held bytes released by a shorter pattern or a later start position.
  task automatic test_held_release();
    rx_mode = RxRandom;
    load_config(pack_text("abcd"), 4'd4, pack_text("R"), 4'd1, 1'b0, 32'd0);
    send_text("abc", 1'b0);
    drain_and_settle();
    write_reg(sfr_pkg::CfgPatternLen, 64'd2);
    cfg_done();
    send_text("x", 1'b0);
    drain_and_settle();
    write_reg(sfr_pkg::CfgPatternLen, 64'd4);
    cfg_done();
    send_text("ab", 1'b0);
    drain_and_settle();
    write_reg(sfr_pkg::CfgStartPosition, 64'hFFFF_FFFF);
    cfg_done();
    send_text("z", 1'b1);
    drain_and_settle();
  endtask

  // The receiver holds off while most bytes expand to eight.
  task automatic test_output_stall();
    int i;
    rx_mode = RxAlways;
    load_config(pack_text("a"), 4'd1, pack_text("ABCDEFGH"), 4'd8, 1'b0, 32'd0);
    rx_hold_len = 150;
    for (i = 0; i < 40; i++) begin
      send_byte(($urandom_range(0, 4) != 0) ? 8'h61 : 8'($urandom_range(0, 255)),
                i == 39);
    end
    drain_and_settle();
  endtask

  // Random settings with texts built mostly from pattern bytes.
  task automatic test_random_texts();
    int          r;
    int          i;
    int          plen;
    int          ntexts;
    int          len;
    int          pp;
    int          t;
    logic [63:0] pat;
    logic [63:0] repl;
    logic [3:0]  pl;
    logic [3:0]  rl;
    logic [31:0] start;
    logic [7:0]  b;
    logic        nocase;
    int          first_item;
    first_item = sent_items;
    while (sent_items - first_item < 225) begin
      r = $urandom_range(0, 99);
      if (r < 10) pl = 4'd0;
      else if (r < 20) pl = 4'($urandom_range(9, 15));
      else if (r < 70) pl = 4'($urandom_range(1, 3));
      else pl = 4'($urandom_range(4, 8));
      plen = (pl == 0) ? 1 : ((pl > sfr_pkg::PatternMax) ? sfr_pkg::PatternMax : pl);
      r = $urandom_range(0, 99);
      pat = {$urandom, $urandom};
      if (r < 5) pat = '1;
      else if (r < 10) pat = '0;
      repl = ($urandom_range(0, 19) == 0) ? '1 : {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 10) rl = 4'($urandom_range(9, 15));
      else if (r < 25) rl = 4'd0;
      else if (r < 70) rl = 4'($urandom_range(1, 3));
      else rl = 4'($urandom_range(4, 8));
      nocase = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      if (r < 60) start = '0;
      else if (r < 90) start = $urandom_range(0, 12);
      else if (r < 95) start = '1;
      else start = $urandom;
      load_config(pat, pl, repl, rl, nocase, start);
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      ntexts = $urandom_range(1, 4);
      for (t = 0; t < ntexts; t++) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        pp = 0;
        for (i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 45) begin
            // Continue planting the pattern.
            b = cfg_pattern[8*pp +: 8];
            pp = (pp + 1) % plen;
          end else if (r < 85) begin
            b = cfg_pattern[8*$urandom_range(0, plen - 1) +: 8];
            pp = 0;
          end else begin
            b = 8'($urandom_range(0, 255));
            pp = 0;
          end
          if (nocase && $urandom_range(0, 2) == 0) b = b ^ sfr_pkg::CaseBit;
          pace_sender();
          send_byte(b, i == len - 1);
        end
      end
      drain_and_settle();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_basic_replace();
    test_ignore_case();
    test_length_limits();
    test_start_position();
    test_held_release();
    test_output_stall();
    test_random_texts();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog in case the core stops responding.
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
